[design/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/msm_pkg.sv]
// shared types and constants of the sample mixer
`default_nettype none
package msm_pkg;

    localparam int VOICES_DEF    = 8;
    localparam int ADDR_BITS_DEF = 16;

    localparam int POS_W   = 18;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 20;
    localparam int VOL_W   = 7;
    localparam int LEN_W   = 17;
    localparam int MASK_W  = 8;
    localparam int PROD_W  = 15;
    localparam int SCALE_W = 17;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [15:0] RECIP_127   = 16'd33027;
    localparam int          RECIP_SHIFT = 22;
    localparam logic [8:0]  SILENCE     = 9'd128;

    localparam logic signed [15:0] SAT_HIGH = 16'sh7fff;
    localparam logic signed [15:0] SAT_LOW  = -16'sh8000;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         voice;
        logic [15:0]        mem_address;
        logic [7:0]         sample_byte;
        logic [LEN_W-1:0]   sound_length;
        logic [STEP_W-1:0]  pitch_step;
        logic [VOL_W-1:0]   left_volume;
        logic [VOL_W-1:0]   right_volume;
        logic signed [15:0] music_left;
        logic signed [15:0] music_right;
    } mix_in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic [MASK_W-1:0]  playing_mask;
    } mix_out_t;

    typedef struct packed {
        logic latch;
        logic mem_wr;
        logic voice_start;
        logic voice_stop;
        logic sums_init;
        logic rd_issue;
        logic mul;
        logic div;
        logic acc;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       sel_playing;
        logic       out_free;
    } ctrl_status_t;

endpackage
`default_nettype wire

[design/msm_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module msm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/msm_ctrl.sv]
// controller state machine sequencing commands and voices
`default_nettype none
module msm_ctrl #(
    parameter int VOICES = msm_pkg::VOICES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire msm_pkg::ctrl_status_t status,
    output msm_pkg::ctrl_cmd_t         ctl,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_sel
);
    import msm_pkg::*;

    localparam int VOICE_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VOICE_BITS-1:0] LAST_VOICE = VOICE_BITS'(VOICES - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_VOICE    = 3'd2;
    localparam logic [2:0] S_MUL      = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_ACC      = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [VOICE_BITS-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        cmd_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.command)
                    CMD_WRITE:
                    begin
                        ctl.mem_wr = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_START:
                    begin
                        ctl.voice_start = 1'b1;
                        state_next      = S_IDLE;
                    end
                    CMD_STOP:
                    begin
                        ctl.voice_stop = 1'b1;
                        state_next     = S_IDLE;
                    end
                    default:
                    begin
                        ctl.sums_init = 1'b1;
                        idx_next      = '0;
                        state_next    = S_VOICE;
                    end
                endcase
            end
            S_VOICE:
            begin
                if (status.sel_playing)
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_MUL;
                end
                else if (idx_reg == LAST_VOICE)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctl.div    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctl.acc = 1'b1;
                if (idx_reg == LAST_VOICE)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_VOICE;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign voice_sel = idx_reg;

endmodule
`default_nettype wire

[design/msm_datapath.sv]
// voice state, sample memory, scaling and mixing datapath
`default_nettype none
module msm_datapath #(
    parameter int VOICES    = msm_pkg::VOICES_DEF,
    parameter int ADDR_BITS = msm_pkg::ADDR_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire msm_pkg::mix_in_t      cmd,
    input  wire msm_pkg::ctrl_cmd_t    ctl,
    input  wire logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_sel,
    output msm_pkg::ctrl_status_t      status,
    output logic                       mix_valid,
    input  wire logic                  mix_stall,
    output msm_pkg::mix_out_t          mix
);
    import msm_pkg::*;

    localparam int VOICE_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W      = 17 + $clog2(VOICES + 1);
    localparam int ACC_W      = STEP_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HIGH_W = SUM_W'(SAT_HIGH);
    localparam logic signed [SUM_W-1:0] SAT_LOW_W  = SUM_W'(SAT_LOW);

    function automatic logic signed [SCALE_W-1:0] scale(input logic [PROD_W-1:0] p,
                                                        input logic neg);
        logic [15:0]        y;
        logic [31:0]        t;
        logic [SCALE_W-1:0] q;
        y = {p, 1'b0};
        t = 32'(y) * 32'(RECIP_127);
        q = SCALE_W'(y) + SCALE_W'(t[31:RECIP_SHIFT]);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    mix_in_t item_reg;

    logic [POS_W-1:0]  pos_reg  [VOICES];
    logic [POS_W-1:0]  end_reg  [VOICES];
    logic [FRAC_W-1:0] frac_reg [VOICES];
    logic [STEP_W-1:0] step_reg [VOICES];
    logic [VOL_W-1:0]  gl_reg   [VOICES];
    logic [VOL_W-1:0]  gr_reg   [VOICES];
    logic [VOICES-1:0] play_reg;

    logic [PROD_W-1:0]        pl_reg, pr_reg;
    logic                     neg_reg;
    logic signed [SCALE_W-1:0] sl_reg, sr_reg;
    logic signed [SUM_W-1:0]  suml_reg, sumr_reg;
    logic                     mix_valid_reg;
    mix_out_t                 mix_reg;

    logic [31:0]           voice32;
    logic [VOICE_BITS-1:0] vidx;
    logic                  vin_range;
    logic [31:0]           wr32, rd32;
    logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [7:0]            rd_data;
    logic signed [8:0]     centered;
    logic [8:0]            mag9;
    logic [ACC_W-1:0]      acc_sum;
    logic [POS_W-1:0]      pos_new;
    logic [MASK_W-1:0]     mask;
    logic signed [15:0]    sat_l, sat_r;

    assign voice32   = 32'(item_reg.voice);
    assign vidx      = voice32[VOICE_BITS-1:0];
    assign vin_range = (voice32 < VOICES);
    assign wr32      = 32'(item_reg.mem_address);
    assign wr_addr   = wr32[ADDR_BITS-1:0];
    assign rd32      = 32'(pos_reg[voice_sel]);
    assign rd_addr   = rd32[ADDR_BITS-1:0];

    msm_ram #(
        .WIDTH (8),
        .DEPTH (2 ** ADDR_BITS)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (ctl.mem_wr),
        .wr_addr (wr_addr),
        .wr_data (item_reg.sample_byte),
        .rd_en   (ctl.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign centered = $signed({1'b0, rd_data}) - $signed(SILENCE);
    assign mag9     = centered[8] ? 9'(-centered) : 9'(centered);
    assign acc_sum  = ACC_W'(frac_reg[voice_sel]) + ACC_W'(step_reg[voice_sel]);
    assign pos_new  = pos_reg[voice_sel] + POS_W'(acc_sum[ACC_W-1:FRAC_W]);

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= cmd;
        end
        if (ctl.voice_start && vin_range)
        begin
            pos_reg[vidx]  <= POS_W'(item_reg.mem_address);
            end_reg[vidx]  <= POS_W'(item_reg.mem_address) + POS_W'(item_reg.sound_length);
            frac_reg[vidx] <= '0;
            step_reg[vidx] <= item_reg.pitch_step;
            gl_reg[vidx]   <= item_reg.left_volume;
            gr_reg[vidx]   <= item_reg.right_volume;
        end
        if (ctl.acc)
        begin
            pos_reg[voice_sel]  <= pos_new;
            frac_reg[voice_sel] <= acc_sum[FRAC_W-1:0];
            suml_reg <= suml_reg + SUM_W'(sl_reg);
            sumr_reg <= sumr_reg + SUM_W'(sr_reg);
        end
        if (ctl.sums_init)
        begin
            suml_reg <= SUM_W'(item_reg.music_left);
            sumr_reg <= SUM_W'(item_reg.music_right);
        end
        if (ctl.mul)
        begin
            pl_reg  <= PROD_W'(gl_reg[voice_sel]) * PROD_W'(mag9[7:0]);
            pr_reg  <= PROD_W'(gr_reg[voice_sel]) * PROD_W'(mag9[7:0]);
            neg_reg <= centered[8];
        end
        if (ctl.div)
        begin
            sl_reg <= scale(pl_reg, neg_reg);
            sr_reg <= scale(pr_reg, neg_reg);
        end
        if (ctl.emit)
        begin
            mix_reg.out_left     <= sat_l;
            mix_reg.out_right    <= sat_r;
            mix_reg.playing_mask <= mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg      <= '0;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.voice_start && vin_range)
            begin
                play_reg[vidx] <= 1'b1;
            end
            if (ctl.voice_stop && vin_range)
            begin
                play_reg[vidx] <= 1'b0;
            end
            if (ctl.acc)
            begin
                play_reg[voice_sel] <= (pos_new < end_reg[voice_sel]);
            end
            if (ctl.emit)
            begin
                mix_valid_reg <= 1'b1;
            end
            else if (!mix_stall)
            begin
                mix_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (suml_reg > SAT_HIGH_W)
            sat_l = SAT_HIGH;
        else if (suml_reg < SAT_LOW_W)
            sat_l = SAT_LOW;
        else
            sat_l = suml_reg[15:0];
        if (sumr_reg > SAT_HIGH_W)
            sat_r = SAT_HIGH;
        else if (sumr_reg < SAT_LOW_W)
            sat_r = SAT_LOW;
        else
            sat_r = sumr_reg[15:0];
    end

    for (genvar i = 0; i < MASK_W; i++)
    begin : g_mask
        if (i < VOICES)
        begin : g_on
            assign mask[i] = play_reg[i];
        end
        else
        begin : g_off
            assign mask[i] = 1'b0;
        end
    end

    assign status.command     = item_reg.command;
    assign status.sel_playing = play_reg[voice_sel];
    assign status.out_free    = !mix_valid_reg || !mix_stall;
    assign mix_valid          = mix_valid_reg;
    assign mix                = mix_reg;

endmodule
`default_nettype wire

[design/multichannel_sample_mixer_core.sv]
// write, start and stop act in the dispatch state; a tick walks the voices in
// turn, each playing one through multiply, scale and accumulate, then waits
// for a free result slot; one transaction at a time, next one accepted after
// the result, set by the serial voice loop through one scaling datapath
// reset: asynchronous active low, all voices idle, no result pending
`default_nettype none
`include "assert_macros.svh"
module multichannel_sample_mixer_core #(
    parameter int VOICES    = msm_pkg::VOICES_DEF,
    parameter int ADDR_BITS = msm_pkg::ADDR_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire msm_pkg::mix_in_t cmd,
    output logic                  mix_valid,
    input  wire logic             mix_stall,
    output msm_pkg::mix_out_t     mix
);
    import msm_pkg::*;

    localparam int VOICE_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;

    ctrl_cmd_t             ctl;
    ctrl_status_t          status;
    logic [VOICE_BITS-1:0] voice_sel;

    msm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctl       (ctl),
        .voice_sel (voice_sel)
    );

    msm_datapath #(
        .VOICES    (VOICES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .voice_sel (voice_sel),
        .status    (status),
        .mix_valid (mix_valid),
        .mix_stall (mix_stall),
        .mix       (mix)
    );

    `ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "accepted while busy")
    `ASSERT_IMPLY(a_emit_free, ctl.emit, !mix_valid || !mix_stall, "result overwritten")
    `ASSERT_ALWAYS(a_one_action, $onehot0({ctl.mem_wr, ctl.voice_start, ctl.voice_stop, ctl.sums_init, ctl.emit, ctl.acc}), "overlapping actions")

endmodule
`default_nettype wire
